### hdl/mexp_pkg.sv
// Package for the modular exponentiation unit.
// Register index codes of the configuration port. No dependencies.
package mexp_pkg;

    // Index of a configuration register in the register map.
    typedef logic [0:0] t_reg_idx;

    localparam t_reg_idx REG_EXPONENT = 1'b0;
    localparam t_reg_idx REG_MODULUS  = 1'b1;

endpackage

### hdl/mexp_ifs.sv
// Valid/ready channel interfaces of the modular exponentiation unit.
// mexp_in_if carries one base, mexp_out_if one result. No dependencies.
interface mexp_in_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] base;

    modport source (output valid, output base, input ready);
    modport sink   (input valid, input base, output ready);
endinterface

interface mexp_out_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] power_result;
    logic         zero_modulus;

    modport source (output valid, output power_result, output zero_modulus, input ready);
    modport sink   (input valid, input power_result, input zero_modulus, output ready);
endinterface

### hdl/modular_exponentiation_unit.sv
// Modular exponentiation unit: power_result = base ^ exponent mod modulus.
// Uses mexp_pkg (register codes) and the channel interfaces in mexp_ifs.sv.
//
// One base in, one result out. Exponent and modulus are to be set through
// the APB port (exponent at byte address 0, modulus at 4; 0 and 8 when
// WIDTH > 32) while the unit is idle; the unit itself does not enforce this.
// The base is first reduced modulo the modulus, then the exponent is scanned
// from its LSB (right-to-left square-and-multiply). All products go through
// one modular multiplier that consumes the multiplier operand one bit per
// cycle, MSB first. An item runs through the reduction, then a multiply for
// each set exponent bit and a square for each exponent bit below the highest
// set bit, then the finishing state. Exponent zero or modulus zero go from
// acceptance straight to the finishing state. A new base is taken once the
// previous result is in the output register; that register holds it until
// it is taken. Modulus zero gives power_result 0 with zero_modulus set.
// Exponent zero with a nonzero modulus gives 1, even for modulus 1.
module modular_exponentiation_unit #(
    parameter int WIDTH = 32,
    localparam int PW   = (WIDTH > 32) ? 64 : 32,
    localparam int AW   = (WIDTH > 32) ? 4 : 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [AW-1:0]  paddr,
    input  logic [PW-1:0]  pwdata,
    output logic [PW-1:0]  prdata,
    output logic           pready,
    // item channels
    mexp_in_if.sink        i_base_ch,
    mexp_out_if.source     o_result_ch
);

    localparam int CW  = $clog2(WIDTH);
    localparam int SW  = WIDTH + 3;                 // 2*acc + a < 3*2^WIDTH, plus sign
    localparam logic [CW-1:0] CNT_TOP = CW'(WIDTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;           // base mod m, as 1 * base
    localparam logic [2:0] S_MUL  = 3'd2;           // r = r * b
    localparam logic [2:0] S_SQR  = 3'd3;           // b = b * b
    localparam logic [2:0] S_FIN  = 3'd4;           // wait for the output register

    // configuration registers
    logic [WIDTH-1:0] r_exp, r_mod;
    mexp_pkg::t_reg_idx w_idx;
    logic             w_wr;

    // control and datapath
    logic [2:0]       r_state, n_state;
    logic [WIDTH-1:0] r_e, n_e;                     // remaining exponent bits
    logic [WIDTH-1:0] r_m, n_m;                     // working modulus
    logic [WIDTH-1:0] r_a, n_a;                     // multiplicand
    logic [WIDTH-1:0] r_mplr, n_mplr;               // multiplier shift register
    logic [WIDTH-1:0] r_acc, n_acc;                 // partial product, kept below m
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_r, n_r;                     // running result
    logic [WIDTH-1:0] r_b, n_b;                     // running power of the base
    logic             r_err, n_err;

    // output register
    logic [WIDTH-1:0] r_res;
    logic             r_zm;
    logic             r_ovalid;
    logic             w_load, w_taken, w_accept, w_last;

    logic [SW-1:0]    w_sum, w_d1, w_d2;
    logic [WIDTH-1:0] w_prod;

    // ---------------- configuration port ----------------
    assign w_idx  = paddr[AW-1];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (w_idx == mexp_pkg::REG_MODULUS) ? PW'(r_mod) : PW'(r_exp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
            r_mod <= '0;
        end else if (w_wr) begin
            if (w_idx == mexp_pkg::REG_EXPONENT) begin
                r_exp <= pwdata[WIDTH-1:0];
            end else begin
                r_mod <= pwdata[WIDTH-1:0];
            end
        end
    end

    // ---------------- bit-serial modular multiply step ----------------
    // acc' = (2*acc + bit*a) mod m; the sum is below 3m, so one of
    // sum, sum - m, sum - 2m is the answer. Both subtractions run in parallel.
    assign w_sum  = {2'b00, r_acc, 1'b0} + (r_mplr[WIDTH-1] ? {3'b000, r_a} : '0);
    assign w_d1   = w_sum - {3'b000, r_m};
    assign w_d2   = w_sum - {2'b00, r_m, 1'b0};
    assign w_last = (r_cnt == '0);

    always_comb begin
        if (!w_d2[SW-1]) begin
            w_prod = w_d2[WIDTH-1:0];
        end else if (!w_d1[SW-1]) begin
            w_prod = w_d1[WIDTH-1:0];
        end else begin
            w_prod = w_sum[WIDTH-1:0];
        end
    end

    // ---------------- sequencer ----------------
    assign i_base_ch.ready = (r_state == S_IDLE);
    assign w_accept        = i_base_ch.valid && i_base_ch.ready;

    always_comb begin
        n_state = r_state;
        n_e     = r_e;
        n_m     = r_m;
        n_a     = r_a;
        n_mplr  = r_mplr;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_r     = r_r;
        n_b     = r_b;
        n_err   = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_m    = r_mod;
                    n_e    = r_exp;
                    n_a    = WIDTH'(1);
                    n_mplr = i_base_ch.base;
                    n_acc  = '0;
                    n_cnt  = CNT_TOP;
                    n_err  = 1'b0;
                    n_r    = (r_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
                    if (r_mod == '0) begin
                        n_r     = '0;
                        n_err   = 1'b1;
                        n_state = S_FIN;
                    end else if (r_exp == '0) begin
                        n_r     = WIDTH'(1);
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RED;
                    end
                end
            end
            S_RED, S_SQR: begin
                n_acc  = w_prod;
                n_mplr = r_mplr << 1;
                n_cnt  = r_cnt - 1'b1;
                if (w_last) begin
                    // new power of the base; pick the next operation
                    n_b   = w_prod;
                    n_acc = '0;
                    n_cnt = CNT_TOP;
                    if (r_e[0]) begin
                        n_state = S_MUL;
                        n_a     = r_r;
                        n_mplr  = w_prod;
                    end else begin
                        n_e     = r_e >> 1;
                        n_state = S_SQR;
                        n_a     = w_prod;
                        n_mplr  = w_prod;
                    end
                end
            end
            S_MUL: begin
                n_acc  = w_prod;
                n_mplr = r_mplr << 1;
                n_cnt  = r_cnt - 1'b1;
                if (w_last) begin
                    n_r   = w_prod;
                    n_e   = r_e >> 1;
                    n_acc = '0;
                    n_cnt = CNT_TOP;
                    if (r_e[WIDTH-1:1] == '0) begin
                        n_state = S_FIN;    // last set bit done, skip the square
                    end else begin
                        n_state = S_SQR;
                        n_a     = r_b;
                        n_mplr  = r_b;
                    end
                end
            end
            S_FIN: begin
                if (!r_ovalid || o_result_ch.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_m    <= n_m;
        r_a    <= n_a;
        r_mplr <= n_mplr;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_r    <= n_r;
        r_b    <= n_b;
        r_err  <= n_err;
    end

    // ---------------- output register ----------------
    assign w_load  = (r_state == S_FIN) && (!r_ovalid || o_result_ch.ready);
    assign w_taken = r_ovalid && o_result_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (w_taken) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= r_r;
            r_zm  <= r_err;
        end
    end

    assign o_result_ch.valid        = r_ovalid;
    assign o_result_ch.power_result = r_res;
    assign o_result_ch.zero_modulus = r_zm;

    // ---------------- assertions ----------------
    // partial product always stays reduced below the working modulus
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED || r_state == S_MUL || r_state == S_SQR) |-> (r_acc < r_m))
        else $error("accumulator not reduced");

    // operands of multiplies and squares are reduced powers of the base
    a_ops_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_SQR) |-> (r_a < r_m && r_b < r_m))
        else $error("operand not reduced");

    // reductions, multiplies and squares are only done while exponent bits remain
    a_exp_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED || r_state == S_MUL || r_state == S_SQR) |-> (r_e != '0))
        else $error("work with an exhausted exponent");

    // an error result carries zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_zm) |-> (r_res == '0))
        else $error("zero modulus with nonzero result");

    // a pending result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_result_ch.ready) |=> (r_ovalid && $stable(r_res)))
        else $error("pending result lost");

endmodule
